FILE: rtl/cam_pkg.sv
// ----------------------------------------------------------------------------
// cam_pkg - shared types and codes for the addressing mode unit
// Phase codes, mode codes, function codes and the result word layout.
// ----------------------------------------------------------------------------
package cam_pkg;

   // function of an incoming word
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_DATA  = 1'b1;

   // addressing mode codes
   localparam logic [3:0] MODE_ACC  = 4'd0;
   localparam logic [3:0] MODE_ABS  = 4'd1;
   localparam logic [3:0] MODE_ABSX = 4'd2;
   localparam logic [3:0] MODE_ABSY = 4'd3;
   localparam logic [3:0] MODE_IMM  = 4'd4;
   localparam logic [3:0] MODE_IMP  = 4'd5;
   localparam logic [3:0] MODE_IND  = 4'd6;
   localparam logic [3:0] MODE_INDX = 4'd7;
   localparam logic [3:0] MODE_INDY = 4'd8;
   localparam logic [3:0] MODE_REL  = 4'd9;
   localparam logic [3:0] MODE_ZPG  = 4'd10;
   localparam logic [3:0] MODE_ZPGX = 4'd11;
   localparam logic [3:0] MODE_ZPGY = 4'd12;

   // byte of an indirect pointer that marks the page-wrap quirk
   localparam logic [7:0] PAGE_LAST = 8'hFF;

   // sequencer phase: which bus read is outstanding
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_OP1,
      PH_OP2,
      PH_PLO,
      PH_PHI
   } phase_type;

   // result word
   typedef struct packed {
      logic              is_request;
      logic [15:0]       bus_addr;
      logic [15:0]       eff_addr;
      logic [15:0]       next_pc;
      logic              acc_operand;
      logic signed [7:0] branch_offset;
      logic              branch_page_cross;
      logic              wrap_extra_cycle;
      logic              protocol_error;
   } rsp_type;

endpackage

FILE: rtl/cam_req_if.sv
// ----------------------------------------------------------------------------
// cam_req_if - input channel of the addressing mode unit
// Valid/ready channel carrying start and read-data words.
// ----------------------------------------------------------------------------
interface cam_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [3:0]  mode;
   logic [15:0] pc_in;
   logic [7:0]  x_index;
   logic [7:0]  y_index;
   logic [7:0]  read_data;

   modport source (output valid, func, mode, pc_in, x_index, y_index, read_data,
                   input ready);
   modport sink   (input valid, func, mode, pc_in, x_index, y_index, read_data,
                   output ready);
endinterface

FILE: rtl/cam_rsp_if.sv
// ----------------------------------------------------------------------------
// cam_rsp_if - result channel of the addressing mode unit
// Valid/ready channel carrying bus read requests and done words.
// ----------------------------------------------------------------------------
interface cam_rsp_if;
   logic              valid;
   logic              ready;
   logic              is_request;
   logic [15:0]       bus_addr;
   logic [15:0]       eff_addr;
   logic [15:0]       next_pc;
   logic              acc_operand;
   logic signed [7:0] branch_offset;
   logic              branch_page_cross;
   logic              wrap_extra_cycle;
   logic              protocol_error;

   modport source (output valid, is_request, bus_addr, eff_addr, next_pc, acc_operand,
                   branch_offset, branch_page_cross, wrap_extra_cycle,
                   protocol_error,
                   input ready);
   modport sink   (input valid, is_request, bus_addr, eff_addr, next_pc, acc_operand,
                   branch_offset, branch_page_cross, wrap_extra_cycle,
                   protocol_error,
                   output ready);
endinterface

FILE: rtl/cpu_addressing_mode_unit.sv
// ----------------------------------------------------------------------------
// cpu_addressing_mode_unit - effective-address sequencer
// Walks the thirteen 8-bit CPU addressing modes one bus beat per word:
// each accepted word yields one result, a bus read request or a done word.
// ----------------------------------------------------------------------------
//
//   channel    dir   handshake          payload
//   req_chan   in    valid / ready      func, mode, pc_in, x_index, y_index,
//                                       read_data
//   rsp_chan   out   valid / ready      is_request, bus_addr, eff_addr, next_pc,
//                                       acc_operand, branch_offset,
//                                       branch_page_cross, wrap_extra_cycle,
//                                       protocol_error
//
// One word per cycle while the output register is empty or being taken:
// each word is decoded combinationally against the held sequencer state
// and its result lands in the output register on the next edge.
// Reset (synchronous) returns the sequencer to idle and empties the output.
// req_chan.ready stays high while the output register is empty or being taken.
// ----------------------------------------------------------------------------
module cpu_addressing_mode_unit (
   input  logic         clock,
   input  logic         reset,
   cam_req_if.sink      req_chan,
   cam_rsp_if.source    rsp_chan
);

   // sequencer state
   cam_pkg::phase_type phase_ff, phase_in;
   logic [3:0]         mode_held_ff, mode_held_in;
   logic [15:0]        pc_held_ff, pc_held_in;
   logic [7:0]         x_held_ff, x_held_in;
   logic [7:0]         y_held_ff, y_held_in;
   logic [7:0]         first_byte_ff, first_byte_in;
   logic [15:0]        pointer_word_ff, pointer_word_in;

   // output register
   logic               rsp_valid_ff;
   cam_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               accept;
   logic [7:0]         data;
   logic [15:0]        word;
   logic [15:0]        npc_one;
   logic [15:0]        npc_two;
   logic [15:0]        rel_target;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign data           = req_chan.read_data;
   assign word           = {data, first_byte_ff};
   assign npc_one        = pc_held_ff + 16'd1;
   assign npc_two        = pc_held_ff + 16'd2;
   assign rel_target     = npc_one + {{8{data[7]}}, data};

   // decode the word against the held state
   always_comb begin
      phase_in        = phase_ff;
      mode_held_in    = mode_held_ff;
      pc_held_in      = pc_held_ff;
      x_held_in       = x_held_ff;
      y_held_in       = y_held_ff;
      first_byte_in   = first_byte_ff;
      pointer_word_in = pointer_word_ff;
      rsp_data_in     = '0;

      if (req_chan.func == cam_pkg::FUNC_START) begin
         // latch operands and either finish or ask for the first operand byte
         mode_held_in = req_chan.mode;
         pc_held_in   = req_chan.pc_in;
         x_held_in    = req_chan.x_index;
         y_held_in    = req_chan.y_index;
         phase_in     = cam_pkg::PH_IDLE;
         priority if (req_chan.mode == cam_pkg::MODE_ACC) begin
            rsp_data_in.next_pc     = req_chan.pc_in;
            rsp_data_in.acc_operand = 1'b1;
         end else if (req_chan.mode == cam_pkg::MODE_IMM) begin
            rsp_data_in.eff_addr = req_chan.pc_in;
            rsp_data_in.next_pc  = req_chan.pc_in + 16'd1;
         end else if (req_chan.mode == cam_pkg::MODE_IMP ||
                      req_chan.mode > cam_pkg::MODE_ZPGY) begin
            rsp_data_in.next_pc = req_chan.pc_in;
         end else begin
            phase_in               = cam_pkg::PH_OP1;
            rsp_data_in.is_request = 1'b1;
            rsp_data_in.bus_addr   = req_chan.pc_in;
         end
      end else begin
         unique case (phase_ff)
            // first operand byte
            cam_pkg::PH_OP1: begin
               first_byte_in = data;
               phase_in      = cam_pkg::PH_IDLE;
               rsp_data_in.next_pc = npc_one;
               unique case (mode_held_ff)
                  cam_pkg::MODE_ZPG: begin
                     rsp_data_in.eff_addr = {8'h00, data};
                  end
                  cam_pkg::MODE_ZPGX: begin
                     rsp_data_in.eff_addr = {8'h00, data + x_held_ff};
                  end
                  cam_pkg::MODE_ZPGY: begin
                     rsp_data_in.eff_addr = {8'h00, data + y_held_ff};
                  end
                  cam_pkg::MODE_REL: begin
                     rsp_data_in.eff_addr          = rel_target;
                     rsp_data_in.branch_offset     = data;
                     rsp_data_in.branch_page_cross = rel_target[15:8] != npc_one[15:8];
                  end
                  cam_pkg::MODE_INDX: begin
                     pointer_word_in      = {8'h00, data + x_held_ff};
                     phase_in             = cam_pkg::PH_PLO;
                     rsp_data_in          = '0;
                     rsp_data_in.is_request = 1'b1;
                     rsp_data_in.bus_addr = {8'h00, data + x_held_ff};
                  end
                  cam_pkg::MODE_INDY: begin
                     pointer_word_in      = {8'h00, data};
                     phase_in             = cam_pkg::PH_PLO;
                     rsp_data_in          = '0;
                     rsp_data_in.is_request = 1'b1;
                     rsp_data_in.bus_addr = {8'h00, data};
                  end
                  default: begin
                     phase_in             = cam_pkg::PH_OP2;
                     rsp_data_in          = '0;
                     rsp_data_in.is_request = 1'b1;
                     rsp_data_in.bus_addr = npc_one;
                  end
               endcase
            end
            // second operand byte completes the absolute word or the indirect pointer
            cam_pkg::PH_OP2: begin
               phase_in            = cam_pkg::PH_IDLE;
               rsp_data_in.next_pc = npc_two;
               unique case (mode_held_ff)
                  cam_pkg::MODE_ABSX: rsp_data_in.eff_addr = word + {8'h00, x_held_ff};
                  cam_pkg::MODE_ABSY: rsp_data_in.eff_addr = word + {8'h00, y_held_ff};
                  cam_pkg::MODE_IND: begin
                     pointer_word_in        = word;
                     phase_in               = cam_pkg::PH_PLO;
                     rsp_data_in            = '0;
                     rsp_data_in.is_request = 1'b1;
                     rsp_data_in.bus_addr   = word;
                  end
                  default: rsp_data_in.eff_addr = word;
               endcase
            end
            // pointer low byte; the high byte address wraps within its page
            cam_pkg::PH_PLO: begin
               first_byte_in          = data;
               phase_in               = cam_pkg::PH_PHI;
               rsp_data_in.is_request = 1'b1;
               if (mode_held_ff == cam_pkg::MODE_IND) begin
                  if (pointer_word_ff[7:0] == cam_pkg::PAGE_LAST) begin
                     rsp_data_in.bus_addr = {pointer_word_ff[15:8], 8'h00};
                  end else begin
                     rsp_data_in.bus_addr = pointer_word_ff + 16'd1;
                  end
               end else begin
                  rsp_data_in.bus_addr = {8'h00, pointer_word_ff[7:0] + 8'd1};
               end
            end
            // pointer high byte finishes the indirect modes
            cam_pkg::PH_PHI: begin
               phase_in = cam_pkg::PH_IDLE;
               if (mode_held_ff == cam_pkg::MODE_IND) begin
                  rsp_data_in.eff_addr         = word;
                  rsp_data_in.next_pc          = npc_two;
                  rsp_data_in.wrap_extra_cycle =
                     pointer_word_ff[7:0] == cam_pkg::PAGE_LAST;
               end else if (mode_held_ff == cam_pkg::MODE_INDY) begin
                  rsp_data_in.eff_addr = word + {8'h00, y_held_ff};
                  rsp_data_in.next_pc  = npc_one;
               end else begin
                  rsp_data_in.eff_addr = word;
                  rsp_data_in.next_pc  = npc_one;
               end
            end
            // data with no read outstanding: flag it, keep state
            default: begin
               rsp_data_in.protocol_error = 1'b1;
            end
         endcase
      end
   end

   // advance sequencer state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= cam_pkg::PH_IDLE;
         mode_held_ff    <= '0;
         pc_held_ff      <= '0;
         x_held_ff       <= '0;
         y_held_ff       <= '0;
         first_byte_ff   <= '0;
         pointer_word_ff <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         mode_held_ff    <= mode_held_in;
         pc_held_ff      <= pc_held_in;
         x_held_ff       <= x_held_in;
         y_held_ff       <= y_held_in;
         first_byte_ff   <= first_byte_in;
         pointer_word_ff <= pointer_word_in;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // drive the result channel
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.is_request        = rsp_data_ff.is_request;
   assign rsp_chan.bus_addr          = rsp_data_ff.bus_addr;
   assign rsp_chan.eff_addr          = rsp_data_ff.eff_addr;
   assign rsp_chan.next_pc           = rsp_data_ff.next_pc;
   assign rsp_chan.acc_operand       = rsp_data_ff.acc_operand;
   assign rsp_chan.branch_offset     = rsp_data_ff.branch_offset;
   assign rsp_chan.branch_page_cross = rsp_data_ff.branch_page_cross;
   assign rsp_chan.wrap_extra_cycle  = rsp_data_ff.wrap_extra_cycle;
   assign rsp_chan.protocol_error    = rsp_data_ff.protocol_error;

endmodule

FILE: verif/addressing_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressing_checker - result checker for the addressing mode unit
// Watches both channels of the unit. It runs its own copy of the address
// sequencer on every accepted input word, queues the result word that each
// one should give, and compares every accepted result word, field by field,
// against the oldest queued one.
// ----------------------------------------------------------------------------
module addressing_checker (
   input  logic        clock,
   input  logic        reset,
   cam_req_if          req_chan,
   cam_rsp_if          rsp_chan,
   output int unsigned fail_count,
   output int unsigned results_seen,
   output int unsigned outstanding
);

   // shadow sequencer state
   cam_pkg::phase_type seq_phase;
   logic [3:0]         held_mode;
   logic [15:0]        held_pc;
   logic [7:0]         held_x;
   logic [7:0]         held_y;
   logic [7:0]         held_byte;
   logic [15:0]        ptr_addr;

   cam_pkg::rsp_type   pending_results[$];
   int unsigned        mismatches;
   int unsigned        checked;

   // advance the shadow sequencer by one word and return the result it gives
   function automatic cam_pkg::rsp_type predict_addressing(
      input logic func, input logic [3:0] mode, input logic [15:0] pc,
      input logic [7:0] x, input logic [7:0] y, input logic [7:0] d);
      cam_pkg::rsp_type r;
      logic [15:0]      word;
      logic [15:0]      npc;
      logic [15:0]      target;
      r = '0;
      // start word: latch the operands and drop any sequence in flight
      if (func == cam_pkg::FUNC_START) begin
         held_mode = mode;
         held_pc   = pc;
         held_x    = x;
         held_y    = y;
         seq_phase = cam_pkg::PH_IDLE;
         case (mode)
            cam_pkg::MODE_ACC: begin
               r.next_pc     = pc;
               r.acc_operand = 1'b1;
            end
            cam_pkg::MODE_IMM: begin
               r.eff_addr = pc;
               r.next_pc  = pc + 16'd1;
            end
            cam_pkg::MODE_ABS, cam_pkg::MODE_ABSX, cam_pkg::MODE_ABSY,
            cam_pkg::MODE_IND, cam_pkg::MODE_INDX, cam_pkg::MODE_INDY,
            cam_pkg::MODE_REL, cam_pkg::MODE_ZPG, cam_pkg::MODE_ZPGX,
            cam_pkg::MODE_ZPGY: begin
               r.is_request = 1'b1;
               r.bus_addr   = pc;
               seq_phase    = cam_pkg::PH_OP1;
            end
            // implied, and the unused codes above the last mode
            default: r.next_pc = pc;
         endcase
         return r;
      end

      // data word: consume the byte for the outstanding read
      case (seq_phase)
         cam_pkg::PH_OP1: begin
            held_byte = d;
            npc       = held_pc + 16'd1;
            r.next_pc = npc;
            case (held_mode)
               cam_pkg::MODE_ZPG:  r.eff_addr = {8'h00, d};
               cam_pkg::MODE_ZPGX: r.eff_addr = {8'h00, d + held_x};
               cam_pkg::MODE_ZPGY: r.eff_addr = {8'h00, d + held_y};
               cam_pkg::MODE_REL: begin
                  target              = npc + {{8{d[7]}}, d};
                  r.eff_addr          = target;
                  r.branch_offset     = d;
                  r.branch_page_cross = (target[15:8] != npc[15:8]);
               end
               cam_pkg::MODE_INDX, cam_pkg::MODE_INDY: begin
                  ptr_addr     = (held_mode == cam_pkg::MODE_INDX) ? {8'h00, d + held_x}
                                                                   : {8'h00, d};
                  r            = '0;
                  r.is_request = 1'b1;
                  r.bus_addr   = ptr_addr;
                  seq_phase    = cam_pkg::PH_PLO;
               end
               default: begin
                  r            = '0;
                  r.is_request = 1'b1;
                  r.bus_addr   = held_pc + 16'd1;
                  seq_phase    = cam_pkg::PH_OP2;
               end
            endcase
         end
         cam_pkg::PH_OP2: begin
            word      = {d, held_byte};
            r.next_pc = held_pc + 16'd2;
            case (held_mode)
               cam_pkg::MODE_ABSX: r.eff_addr = word + held_x;
               cam_pkg::MODE_ABSY: r.eff_addr = word + held_y;
               cam_pkg::MODE_IND: begin
                  ptr_addr     = word;
                  r            = '0;
                  r.is_request = 1'b1;
                  r.bus_addr   = word;
                  seq_phase    = cam_pkg::PH_PLO;
               end
               default:   r.eff_addr = word;
            endcase
         end
         cam_pkg::PH_PLO: begin
            // pointer low byte: the high byte read stays on the pointer's page
            held_byte    = d;
            r.is_request = 1'b1;
            seq_phase    = cam_pkg::PH_PHI;
            if (held_mode == cam_pkg::MODE_IND) begin
               r.bus_addr = (ptr_addr[7:0] == cam_pkg::PAGE_LAST) ? {ptr_addr[15:8], 8'h00}
                                                                  : ptr_addr + 16'd1;
            end else begin
               r.bus_addr = {8'h00, ptr_addr[7:0] + 8'd1};
            end
         end
         cam_pkg::PH_PHI: begin
            word = {d, held_byte};
            if (held_mode == cam_pkg::MODE_IND) begin
               r.eff_addr         = word;
               r.next_pc          = held_pc + 16'd2;
               r.wrap_extra_cycle = (ptr_addr[7:0] == cam_pkg::PAGE_LAST);
            end else begin
               r.eff_addr = (held_mode == cam_pkg::MODE_INDY) ? word + held_y : word;
               r.next_pc  = held_pc + 16'd1;
            end
         end
         // no read outstanding: flag it and leave the state alone
         default: r.protocol_error = 1'b1;
      endcase
      if (!r.is_request) begin
         seq_phase = cam_pkg::PH_IDLE;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   // sample both channels at the clock edge
   always @(posedge clock) begin
      cam_pkg::rsp_type want;
      cam_pkg::rsp_type got;
      if (reset) begin
         seq_phase = cam_pkg::PH_IDLE;
         held_mode = '0;
         held_pc   = '0;
         held_x    = '0;
         held_y    = '0;
         held_byte = '0;
         ptr_addr  = '0;
         pending_results.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            pending_results.push_back(predict_addressing(req_chan.func, req_chan.mode,
                                                         req_chan.pc_in, req_chan.x_index,
                                                         req_chan.y_index,
                                                         req_chan.read_data));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            checked++;
            got.is_request        = rsp_chan.is_request;
            got.bus_addr          = rsp_chan.bus_addr;
            got.eff_addr          = rsp_chan.eff_addr;
            got.next_pc           = rsp_chan.next_pc;
            got.acc_operand       = rsp_chan.acc_operand;
            got.branch_offset     = rsp_chan.branch_offset;
            got.branch_page_cross = rsp_chan.branch_page_cross;
            got.wrap_extra_cycle  = rsp_chan.wrap_extra_cycle;
            got.protocol_error    = rsp_chan.protocol_error;
            if (pending_results.size() == 0) begin
               $error("result word with no input word waiting for it");
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("is_request", want.is_request, got.is_request);
               check_field("bus_addr", want.bus_addr, got.bus_addr);
               check_field("eff_addr", want.eff_addr, got.eff_addr);
               check_field("next_pc", want.next_pc, got.next_pc);
               check_field("acc_operand", want.acc_operand, got.acc_operand);
               check_field("branch_offset", want.branch_offset, got.branch_offset);
               check_field("branch_page_cross", want.branch_page_cross,
                           got.branch_page_cross);
               check_field("wrap_extra_cycle", want.wrap_extra_cycle, got.wrap_extra_cycle);
               check_field("protocol_error", want.protocol_error, got.protocol_error);
            end
         end
      end
      fail_count   <= mismatches;
      results_seen <= checked;
      outstanding  <= pending_results.size();
   end

endmodule

FILE: verif/cpu_addressing_mode_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_addressing_mode_unit_tb - testbench for the addressing mode unit
// Drives start and read-data words into the unit with random input gaps and
// output back-pressure: a short directed run over the wrap cases, then random
// instruction sequences, mostly complete, some cut short by a new start and
// some followed by a stray data word. A separate checker predicts and
// compares every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module cpu_addressing_mode_unit_tb;

   localparam int unsigned PHASE_WORDS    = 480;
   localparam int unsigned HOLD_CYCLES    = 60;
   localparam int unsigned TIMEOUT_CYCLES = 200000;

   logic        clock = 1'b0;
   logic        reset;

   cam_req_if   req_chan ();
   cam_rsp_if   rsp_chan ();

   int unsigned fail_count;
   int unsigned results_seen;
   int unsigned outstanding;

   int unsigned req_idle_pct = 8;
   int unsigned rsp_idle_pct = 59;
   int unsigned holds_asked  = 0;
   int unsigned holds_done   = 0;
   int unsigned hold_left    = 0;
   int unsigned cycle_count  = 0;
   int unsigned words_sent   = 0;
   int unsigned starts_sent  = 0;
   bit          mode_seen[16];

   cpu_addressing_mode_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   addressing_checker addr_check (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .fail_count   (fail_count),
      .results_seen (results_seen),
      .outstanding  (outstanding)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // drive the result side: random back-pressure plus one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done = holds_asked;
         hold_left  = HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // operand bytes the unit reads before it finishes a mode
   function automatic int unsigned operand_reads(input logic [3:0] mode);
      case (mode)
         cam_pkg::MODE_ZPG, cam_pkg::MODE_ZPGX, cam_pkg::MODE_ZPGY,
         cam_pkg::MODE_REL:                                          return 1;
         cam_pkg::MODE_ABS, cam_pkg::MODE_ABSX, cam_pkg::MODE_ABSY: return 2;
         cam_pkg::MODE_INDX, cam_pkg::MODE_INDY:                     return 3;
         cam_pkg::MODE_IND:                                          return 4;
         default:                                                    return 0;
      endcase
   endfunction

   // bias toward the page-edge bytes
   function automatic logic [7:0] pick_byte();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 20) return 8'hFF;
      if (roll < 25) return 8'h00;
      return 8'($urandom);
   endfunction

   // offer one word and hold it until the unit takes it
   task automatic offer_word(input logic func, input logic [3:0] mode,
                             input logic [15:0] pc, input logic [7:0] x,
                             input logic [7:0] y, input logic [7:0] data);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.func      <= func;
      req_chan.mode      <= mode;
      req_chan.pc_in     <= pc;
      req_chan.x_index   <= x;
      req_chan.y_index   <= y;
      req_chan.read_data <= data;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
   endtask

   task automatic send_start(input logic [3:0] mode, input logic [15:0] pc,
                             input logic [7:0] x, input logic [7:0] y);
      offer_word(cam_pkg::FUNC_START, mode, pc, x, y, 8'($urandom));
      starts_sent++;
      mode_seen[mode] = 1'b1;
   endtask

   // the start-only fields carry noise on data words
   task automatic send_data(input logic [7:0] data);
      offer_word(cam_pkg::FUNC_DATA, 4'($urandom), 16'($urandom), 8'($urandom),
                 8'($urandom), data);
   endtask

   // drop valid and wait until every result word has come back
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // one instruction: start, its operand reads, sometimes cut or followed by noise
   task automatic random_sequence();
      logic [3:0]  mode;
      logic [15:0] pc;
      int unsigned reads;
      bit          cut;
      mode  = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 13))
                                        : 4'($urandom_range(12, 0));
      pc    = ($urandom_range(9) == 0) ? 16'hFFFF - 16'($urandom_range(2)) : 16'($urandom);
      reads = operand_reads(mode);
      cut   = (reads != 0) && ($urandom_range(9) == 0);
      if (cut) begin
         reads = $urandom_range(reads - 1);
      end
      send_start(mode, pc, pick_byte(), pick_byte());
      repeat (reads) send_data(pick_byte());
      if (!cut && $urandom_range(24) == 0) begin
         send_data(pick_byte());
      end
   endtask

   initial begin
      int unsigned phase_end;
      int unsigned modes_hit;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.func      <= cam_pkg::FUNC_START;
      req_chan.mode      <= cam_pkg::MODE_ACC;
      req_chan.pc_in     <= '0;
      req_chan.x_index   <= '0;
      req_chan.y_index   <= '0;
      req_chan.read_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: data with nothing outstanding right after reset
      send_data(8'hFF);
      // modes that finish at once, two of them with the PC at the top of memory
      send_start(cam_pkg::MODE_ACC, 16'hFFFF, 8'hFF, 8'hFF);
      send_start(cam_pkg::MODE_IMM, 16'hFFFF, 8'h00, 8'h00);
      send_start(cam_pkg::MODE_IMP, 16'h0000, 8'hFF, 8'h00);
      send_start(4'hF, 16'h8000, 8'h00, 8'hFF);
      // zero-page index wraps inside page zero
      send_start(cam_pkg::MODE_ZPGY, 16'h0000, 8'h00, 8'hFF);
      send_data(8'hFF);
      // most negative branch from the top of memory crosses a page
      send_start(cam_pkg::MODE_REL, 16'hFFFF, 8'h00, 8'h00);
      send_data(8'h80);
      // indirect jump through a pointer at the end of a page
      send_start(cam_pkg::MODE_IND, 16'h1234, 8'h00, 8'h00);
      send_data(8'hFF);
      send_data(8'h12);
      send_data(8'h34);
      send_data(8'h56);
      // indirect indexed: pointer at FF wraps to 00, sum wraps at 16 bits
      send_start(cam_pkg::MODE_INDY, 16'h0100, 8'h00, 8'hFF);
      send_data(8'hFF);
      send_data(8'hFF);
      send_data(8'hFF);
      // absolute indexed wraps at 16 bits
      send_start(cam_pkg::MODE_ABSX, 16'hFFFE, 8'hFF, 8'h00);
      send_data(8'hFF);
      send_data(8'hFF);
      // new start while a read is outstanding
      send_start(cam_pkg::MODE_ABS, 16'h4000, 8'h00, 8'h00);
      send_data(8'h00);
      send_start(cam_pkg::MODE_ZPG, 16'h4000, 8'h00, 8'h00);
      send_data(8'h7F);
      drain_results();

      // random: three idle profiles, the last one with a long output hold
      for (int p = 0; p < 3; p++) begin
         req_idle_pct = (p == 0) ? 8 : (p == 1) ? 59 : 0;
         rsp_idle_pct <= (p == 0) ? 59 : (p == 1) ? 8 : 0;
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) begin
            random_sequence();
            if (p == 2 && holds_asked == 0 && words_sent > phase_end - PHASE_WORDS / 2) begin
               holds_asked <= holds_asked + 1;
            end
         end
         drain_results();
      end

      repeat (4) @(posedge clock);
      modes_hit = 0;
      foreach (mode_seen[m]) begin
         modes_hit += mode_seen[m];
      end
      $display("Covered %0d words (%0d starts over %0d of 16 mode codes) and checked %0d results,",
               words_sent, starts_sent, modes_hit, results_seen);
      $display("with restarts, stray data, a %0d-cycle output hold and three idle profiles.",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/cam_pkg.sv
rtl/cam_req_if.sv
rtl/cam_rsp_if.sv
rtl/cpu_addressing_mode_unit.sv
verif/addressing_checker.sv
verif/cpu_addressing_mode_unit_tb.sv
